// File: rtl/core/kmp_pkg.sv
// shared types and constants for the streaming kmp matcher
// no dependencies; imported by every module of the block
package kmp_pkg;

    localparam int MAX_PATTERN   = 64;
    localparam int POSITION_BITS = 32;
    localparam int ADDR_W        = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LEN_W         = $clog2(MAX_PATTERN + 1);
    localparam int START_W       = 32;
    localparam int TOTAL_W       = 32;
    localparam int STATUS_W      = 2;

    typedef enum logic [1:0] {
        CMD_NEW_PATTERN = 2'd0,
        CMD_APPEND      = 2'd1,
        CMD_NEW_TEXT    = 2'd2,
        CMD_TEXT_BYTE   = 2'd3
    } t_cmd;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        t_cmd       command;
        logic [7:0] data_byte;
    } t_in_word;

    typedef struct packed {
        logic                match_found;
        logic [START_W-1:0]  match_start;
        logic [TOTAL_W-1:0]  match_total;
        logic [STATUS_W-1:0] status;
    } t_out_word;

    // write side of the pattern and link stores
    typedef struct packed {
        logic              pat_we;
        logic [ADDR_W-1:0] pat_addr;
        logic [7:0]        pat_data;
        logic              link_we;
        logic [ADDR_W-1:0] link_addr;
        logic [ADDR_W-1:0] link_data;
    } t_store_wr;

    // registered read data: pattern[c], link[c], link[c-1]
    typedef struct packed {
        logic [7:0]        pat;
        logic [ADDR_W-1:0] link;
        logic [ADDR_W-1:0] link_prev;
    } t_store_rd;

    typedef struct packed {
        logic eq;
        logic step;
        logic at_end;
    } t_walk;

endpackage

// File: rtl/core/kmp_store.sv
// pattern byte store and failure-link store, registered reads
// depends on kmp_pkg
module kmp_store (
    input  logic                          i_clk,
    input  kmp_pkg::t_store_wr            i_wr,
    input  logic [kmp_pkg::ADDR_W-1:0]    i_rd_addr,
    output kmp_pkg::t_store_rd            o_rd
);
    import kmp_pkg::*;

    logic [7:0]        r_pat_mem  [MAX_PATTERN];
    logic [ADDR_W-1:0] r_link_mem [MAX_PATTERN];
    logic [ADDR_W-1:0] rd_prev;

    // wraps when the cursor is zero; that read is never used
    assign rd_prev = i_rd_addr - ADDR_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_wr.pat_we) begin
            r_pat_mem[i_wr.pat_addr] <= i_wr.pat_data;
        end
        if (i_wr.link_we) begin
            r_link_mem[i_wr.link_addr] <= i_wr.link_data;
        end
        o_rd.pat       <= r_pat_mem[i_rd_addr];
        o_rd.link      <= r_link_mem[i_rd_addr];
        o_rd.link_prev <= r_link_mem[rd_prev];
    end

endmodule

// File: rtl/core/kmp_walk.sv
// byte compare unit shared by pattern build and text matching
// depends on kmp_pkg
module kmp_walk (
    input  logic                       i_active,
    input  logic [7:0]                 i_byte,
    input  logic [kmp_pkg::ADDR_W-1:0] i_cur,
    input  logic [kmp_pkg::LEN_W-1:0]  i_len,
    input  kmp_pkg::t_store_rd         i_rd,
    output kmp_pkg::t_walk             o_res
);
    import kmp_pkg::*;

    always_comb begin
        o_res.eq     = (i_rd.pat == i_byte);
        // mismatch with a nonzero cursor follows one more failure link
        o_res.step   = i_active && !o_res.eq && (i_cur != '0);
        o_res.at_end = (LEN_W'(i_cur) == (i_len - LEN_W'(1)));
    end

endmodule

// File: rtl/core/kmp_stream_matcher_top.sv
// streaming kmp matcher top level: sequencer, cursors, counters, result register
// depends on kmp_pkg, kmp_store, kmp_walk
//
// Each input word gives exactly one result word; it is written to the output register
// from the run state once no failure link is left and the output register is free.
// Each failure link followed adds a pass through the run state, since the single byte
// comparator and the link store's registered read port handle one link per cycle.
// Over a text the links followed average below one per byte. The
// input is ready only while the sequencer is idle; a finished result waits in the
// output register without blocking the next word, which stalls only if it finishes
// while the previous result has still not been taken. Start positions are 0-based;
// position and match count saturate at their all-ones value.
module kmp_stream_matcher_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  kmp_pkg::t_in_word  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output kmp_pkg::t_out_word o_out_data
);
    import kmp_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state                   r_state,     n_state;
    t_cmd                     r_cmd,       n_cmd;
    logic [7:0]               r_byte,      n_byte;
    logic [ADDR_W-1:0]        r_cur,       n_cur;
    logic                     r_walk,      n_walk;
    logic [LEN_W-1:0]         r_len,       n_len;
    logic [ADDR_W-1:0]        r_bc,        n_bc;
    logic [ADDR_W-1:0]        r_mc,        n_mc;
    logic [POSITION_BITS-1:0] r_pos,       n_pos;
    logic [TOTAL_W-1:0]       r_cnt,       n_cnt;
    logic                     r_out_valid, n_out_valid;
    t_out_word                r_out,       n_out;

    t_store_wr                wr;
    t_store_rd                rd;
    logic [ADDR_W-1:0]        rd_addr;
    t_walk                    walk;
    logic                     accept;
    logic                     out_free;
    logic [ADDR_W-1:0]        new_link;
    logic [POSITION_BITS-1:0] start_pos;

    kmp_store u_store (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_addr (rd_addr),
        .o_rd      (rd)
    );

    kmp_walk u_walk (
        .i_active (r_walk),
        .i_byte   (r_byte),
        .i_cur    (r_cur),
        .i_len    (r_len),
        .i_rd     (rd),
        .o_res    (walk)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign accept      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    // a mismatch that ends the walk leaves the cursor at zero
    assign new_link  = (r_walk && walk.eq) ? (r_cur + ADDR_W'(1)) : '0;
    assign start_pos = r_pos - (POSITION_BITS'(r_len) - POSITION_BITS'(1));

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_byte      = r_byte;
        n_cur       = r_cur;
        n_walk      = r_walk;
        n_len       = r_len;
        n_bc        = r_bc;
        n_mc        = r_mc;
        n_pos       = r_pos;
        n_cnt       = r_cnt;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        wr          = '0;
        rd_addr     = r_cur;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd   = i_in_data.command;
                    n_byte  = i_in_data.data_byte;
                    n_state = S_RUN;
                    n_walk  = 1'b0;
                    n_cur   = '0;
                    case (i_in_data.command)
                        CMD_APPEND: begin
                            if (r_len < LEN_W'(MAX_PATTERN)) begin
                                wr.pat_we   = 1'b1;
                                wr.pat_addr = r_len[ADDR_W-1:0];
                                wr.pat_data = i_in_data.data_byte;
                                n_walk      = (r_len != '0);
                                n_cur       = r_bc;
                                rd_addr     = r_bc;
                            end
                        end
                        CMD_TEXT_BYTE: begin
                            if (r_len != '0) begin
                                n_walk  = 1'b1;
                                n_cur   = r_mc;
                                rd_addr = r_mc;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RUN: begin
                if (walk.step) begin
                    n_cur   = rd.link_prev;
                    rd_addr = rd.link_prev;
                end else if (out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    case (r_cmd)
                        CMD_NEW_PATTERN: begin
                            n_len = '0;
                            n_bc  = '0;
                            n_mc  = '0;
                            n_pos = '0;
                            n_cnt = '0;
                        end
                        CMD_NEW_TEXT: begin
                            n_mc  = '0;
                            n_pos = '0;
                            n_cnt = '0;
                        end
                        CMD_APPEND: begin
                            n_out.match_total = r_cnt;
                            if (r_len >= LEN_W'(MAX_PATTERN)) begin
                                n_out.status = ST_FULL;
                            end else begin
                                wr.link_we   = 1'b1;
                                wr.link_addr = r_len[ADDR_W-1:0];
                                wr.link_data = new_link;
                                n_bc         = new_link;
                                n_len        = r_len + LEN_W'(1);
                            end
                        end
                        CMD_TEXT_BYTE: begin
                            if (r_pos != '1) begin
                                n_pos = r_pos + POSITION_BITS'(1);
                            end
                            if (!r_walk) begin
                                n_out.status = ST_EMPTY;
                            end else if (walk.eq) begin
                                if (walk.at_end) begin
                                    n_out.match_found = 1'b1;
                                    n_out.match_start = START_W'(start_pos);
                                    if (r_cnt != '1) begin
                                        n_cnt = r_cnt + TOTAL_W'(1);
                                    end
                                    // overlap: fall back to the link of the last byte
                                    n_mc = rd.link;
                                end else begin
                                    n_mc = r_cur + ADDR_W'(1);
                                end
                            end else begin
                                n_mc = '0;
                            end
                            n_out.match_total = n_cnt;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_byte <= n_byte;
        r_cur  <= n_cur;
        r_walk <= n_walk;
        r_out  <= n_out;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_len       <= '0;
            r_bc        <= '0;
            r_mc        <= '0;
            r_pos       <= '0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_len       <= n_len;
            r_bc        <= n_bc;
            r_mc        <= n_mc;
            r_pos       <= n_pos;
            r_cnt       <= n_cnt;
        end
    end

endmodule

// File: tb/kmp_match_checker.sv
`timescale 1ns / 100ps
// result checker for the streaming kmp matcher: watches both channels, predicts each result
// word from the accepted input words and compares field by field; depends on kmp_pkg
module kmp_match_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  kmp_pkg::t_in_word  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  kmp_pkg::t_out_word i_out_data,
    output int                 o_errors,
    output int                 o_pending
);
    import kmp_pkg::*;

    logic [7:0]               pattern_mem [MAX_PATTERN];
    int                       link_mem    [MAX_PATTERN];
    int                       pat_len;
    int                       build_pos;
    int                       scan_pos;
    logic [POSITION_BITS-1:0] text_pos;
    logic [TOTAL_W-1:0]       hit_count;

    t_out_word expected_words[$];
    int        errors;

    initial begin
        foreach (pattern_mem[k]) begin
            pattern_mem[k] = '0;
            link_mem[k]    = 0;
        end
        pat_len   = 0;
        build_pos = 0;
        scan_pos  = 0;
        text_pos  = '0;
        hit_count = '0;
        errors    = 0;
    end

    function automatic t_out_word predict_result(input t_in_word w);
        t_out_word                r;
        int                       c;
        logic [POSITION_BITS-1:0] pos;
        r = '0;
        case (w.command)
            CMD_NEW_PATTERN: begin
                pat_len   = 0;
                build_pos = 0;
                scan_pos  = 0;
                text_pos  = '0;
                hit_count = '0;
            end
            CMD_APPEND: begin
                if (pat_len >= MAX_PATTERN) begin
                    r.status = ST_FULL;
                end else begin
                    pattern_mem[pat_len] = w.data_byte;
                    if (pat_len == 0) begin
                        build_pos = 0;
                    end else begin
                        while (build_pos > 0 && pattern_mem[build_pos] != w.data_byte)
                            build_pos = link_mem[build_pos-1];
                        if (pattern_mem[build_pos] == w.data_byte)
                            build_pos++;
                    end
                    link_mem[pat_len] = build_pos;
                    pat_len++;
                end
            end
            CMD_NEW_TEXT: begin
                scan_pos  = 0;
                text_pos  = '0;
                hit_count = '0;
            end
            default: begin
                pos = text_pos;
                if (text_pos != '1)
                    text_pos++;
                if (pat_len == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    c = scan_pos;
                    while (c > 0 && pattern_mem[c] != w.data_byte)
                        c = link_mem[c-1];
                    if (pattern_mem[c] == w.data_byte) begin
                        if (c == pat_len - 1) begin
                            r.match_found = 1'b1;
                            r.match_start = START_W'(pos - POSITION_BITS'(pat_len - 1));
                            if (hit_count != '1)
                                hit_count++;
                            // overlapping hits: fall back along the last link
                            c = link_mem[c];
                        end else begin
                            c++;
                        end
                    end
                    scan_pos = c;
                end
            end
        endcase
        r.match_total = hit_count;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_out_word want;
        if (i_rst_n) begin
            // the result of a word taken this edge cannot leave at the same edge
            if (i_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result word, expected none, got %h",
                             $time, i_out_data);
                end else begin
                    want = expected_words.pop_front();
                    check_field("match_found", 32'(want.match_found), 32'(i_out_data.match_found));
                    check_field("match_start", want.match_start, i_out_data.match_start);
                    check_field("match_total", want.match_total, i_out_data.match_total);
                    check_field("status", 32'(want.status), 32'(i_out_data.status));
                end
            end
            if (i_in_valid && i_in_ready)
                expected_words = {expected_words, predict_result(i_in_data)};
        end
        o_errors  <= errors;
        o_pending <= expected_words.size();
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// top of the kmp matcher testbench: clock, reset, word stimulus, result sink and verdict
// depends on kmp_pkg, kmp_stream_matcher_top and kmp_match_checker
module testbench;
    import kmp_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int TARGET_WORDS = 550;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_word  in_word;
    logic      out_valid;
    logic      out_ready;
    t_out_word out_word;
    int        errors;
    int        pending;

    int         items_sent = 0;
    int         cycles = 0;
    bit         send_fast = 1'b0;
    logic [7:0] sym_a;
    logic [7:0] sym_b;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    kmp_stream_matcher_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_word)
    );

    kmp_match_checker i_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_word),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_word),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("** kmp_stream_matcher_top: FAILED **");
            $finish;
        end
    end

    task automatic send_word(input t_cmd cmd, input logic [7:0] value);
        int       gap;
        t_in_word w;
        if ($urandom_range(0, 29) == 0)
            send_fast = !send_fast;
        gap = send_fast ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        w.command   = cmd;
        w.data_byte = value;
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // mostly two close symbols so that hits and link walks are frequent
    function automatic logic [7:0] next_symbol();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return sym_a;
        else if (r < 9)
            return sym_b;
        return 8'($urandom);
    endfunction

    initial begin : result_sink
        int stall;
        int taken;
        bit fast;
        bit held;
        taken = 0;
        fast  = 1'b0;
        held  = 1'b0;
        out_ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if ($urandom_range(0, 29) == 0)
                fast = !fast;
            stall = fast ? 0 : $urandom_range(0, 7);
            // one long hold-off so the block backs up and stalls its input
            if (!held && taken == 150) begin
                stall = 120;
                held  = 1'b1;
            end
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            taken++;
        end
    end

    initial begin : word_source
        int  kind;
        int  plen;
        int  tlen;
        bit  first;
        bit  paused;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_word  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // text with no pattern, then overlapping hits, append mid-text, fresh text, one-byte pattern
        send_word(CMD_TEXT_BYTE, 8'h00);
        send_word(CMD_TEXT_BYTE, 8'hFF);
        send_word(CMD_NEW_PATTERN, 8'hFF);
        send_word(CMD_APPEND, 8'h00);
        send_word(CMD_APPEND, 8'hFF);
        send_word(CMD_APPEND, 8'h00);
        send_word(CMD_TEXT_BYTE, 8'h00);
        send_word(CMD_TEXT_BYTE, 8'hFF);
        send_word(CMD_TEXT_BYTE, 8'h00);
        send_word(CMD_TEXT_BYTE, 8'hFF);
        send_word(CMD_TEXT_BYTE, 8'h00);
        send_word(CMD_APPEND, 8'hFF);
        send_word(CMD_TEXT_BYTE, 8'hFF);
        send_word(CMD_TEXT_BYTE, 8'h00);
        send_word(CMD_TEXT_BYTE, 8'hFF);
        send_word(CMD_NEW_TEXT, 8'h00);
        send_word(CMD_TEXT_BYTE, 8'h00);
        send_word(CMD_TEXT_BYTE, 8'hFF);
        send_word(CMD_TEXT_BYTE, 8'h00);
        send_word(CMD_TEXT_BYTE, 8'hFF);
        send_word(CMD_NEW_PATTERN, 8'h00);
        send_word(CMD_APPEND, 8'h7F);
        send_word(CMD_TEXT_BYTE, 8'h7F);
        send_word(CMD_TEXT_BYTE, 8'h80);
        drain_results();

        first  = 1'b1;
        paused = 1'b0;
        while (items_sent < TARGET_WORDS) begin
            kind = $urandom_range(0, 9);
            if (first)
                kind = 2;
            if (kind == 0) begin
                // noise: any word at all
                repeat ($urandom_range(1, 8))
                    send_word(t_cmd'($urandom_range(0, 3)), 8'($urandom));
            end else begin
                sym_a = 8'($urandom);
                sym_b = $urandom_range(0, 1) ? sym_a ^ (8'h01 << $urandom_range(0, 7))
                                             : 8'($urandom);
                // first run overfills the pattern store; long ones stay rare
                if (first)
                    plen = MAX_PATTERN + 3;
                else if ($urandom_range(0, 15) == 0)
                    plen = $urandom_range(7, MAX_PATTERN + 2);
                else
                    plen = $urandom_range(1, 6);
                send_word(CMD_NEW_PATTERN, 8'($urandom));
                repeat (plen)
                    send_word(CMD_APPEND, next_symbol());
                if (kind != 1)
                    send_word(CMD_NEW_TEXT, 8'($urandom));
                tlen = $urandom_range(8, 40);
                repeat (tlen) begin
                    if ($urandom_range(0, 40) == 0)
                        send_word(CMD_APPEND, next_symbol());
                    send_word(CMD_TEXT_BYTE, next_symbol());
                end
            end
            if (!paused && items_sent > 300) begin
                drain_results();
                paused = 1'b1;
            end
            first = 1'b0;
        end

        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (20) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("** kmp_stream_matcher_top: PASSED **");
        else
            $display("** kmp_stream_matcher_top: FAILED **");
        $finish;
    end

endmodule
